// ----- rtl/core/sincos_pkg.sv -----
// shared constants and types for the sine / cosine polynomial pipeline
`default_nettype none

package sincos_pkg;

  // default port widths
  localparam int ANGLE_WIDTH_DEF  = 32;
  localparam int RESULT_WIDTH_DEF = 32;

  // fraction bits of the polynomial arithmetic
  localparam int Q_FRAC = 30;

  // clock edges from the accepting edge to the edge that takes the result
  localparam int LATENCY = 17;

  // q30 working word
  typedef logic signed [31:0] q30_t;

  // range reduction constants
  localparam logic signed [32:0] PI_HALF_Q27 = 33'sd210828714;
  localparam logic        [30:0] INV_PI_Q32  = 31'd1367130551;
  localparam logic        [63:0] PI_Q58      = 64'h0C90_FDAA_2216_8C23;

  // minimax coefficients in q30
  localparam q30_t COEF_A  = -32'sd198515;
  localparam q30_t COEF_B  = 32'sd8924834;
  localparam q30_t COEF_C  = -32'sd178945024;
  localparam q30_t COEF_D  = 32'sd1073740816;
  localparam q30_t ONE_Q30 = 32'sd1073741824;

endpackage

`default_nettype wire

// ----- rtl/core/sincos_mac.sv -----
// two-stage multiply, round to q30 and add unit
`default_nettype none

module sincos_mac #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] in_a,
  input  logic signed [BW-1:0] in_b,
  input  logic signed [CW-1:0] in_c,
  output logic                 out_vld,
  output logic signed [CW-1:0] out_res
);
  import sincos_pkg::*;

  localparam int PW = AW + BW;

  logic                 vld1_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [CW-1:0] c_r;
  logic signed [PW-1:0] half;
  logic signed [PW-1:0] neg_adj;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] shifted;
  logic                 vld2_r;
  logic signed [CW-1:0] res_r;
  logic signed [CW-1:0] res_nxt;

  // full width signed product
  assign prod_nxt = PW'(in_a) * PW'(in_b);

  // round to nearest, ties away from zero, then add the coefficient
  assign half    = {{(PW - Q_FRAC){1'b0}}, 1'b1, {(Q_FRAC - 1){1'b0}}};
  assign neg_adj = $signed({{(PW - 1){1'b0}}, prod_r[PW-1]});
  assign biased  = prod_r + half - neg_adj;
  assign shifted = biased >>> Q_FRAC;
  assign res_nxt = c_r + CW'(shifted);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    c_r    <= in_c;
    res_r  <= res_nxt;
  end

  assign out_vld = vld2_r;
  assign out_res = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/sine_cosine_polynomial_approx.sv -----
// sine / cosine by a degree-7 odd minimax polynomial, fully pipelined
// usage:
//   start with in_command (0 sine, 1 cosine) and in_angle (signed, 27 fraction
//   bits) hands one word in; it is taken at a rising edge where start is high
//   and busy is low. busy is high only while rst_n is low.
//   out_strobe marks out_value (signed q1.30, clamped to plus or minus one)
//   for exactly one cycle; the receiver has no way to hold results off.
// throughput and depth:
//   one word may enter every cycle; the depth is set by the chain of five
//   two-stage multiply units (square, three horner steps, final product)
//   behind six range reduction stages and an output register.
// reset:
//   synchronous reset clears every valid bit, so words in flight are dropped
//   and no strobe follows; the data registers are not reset.
`default_nettype none

module sine_cosine_polynomial_approx #(
  parameter int ANGLE_WIDTH  = sincos_pkg::ANGLE_WIDTH_DEF,
  parameter int RESULT_WIDTH = sincos_pkg::RESULT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic signed [ANGLE_WIDTH-1:0]  in_angle,
  output logic                           out_strobe,
  output logic signed [RESULT_WIDTH-1:0] out_value
);
  import sincos_pkg::*;

  // multiple of pi for the range reduction, q in 0..15
  function automatic logic [63:0] npi_of(input logic [3:0] q);
    return 64'(q) * PI_Q58;
  endfunction

  logic                    acc;
  logic signed [31:0]      ang_sat;
  logic signed [32:0]      x1_nxt;
  logic                    vld1_r;
  logic signed [32:0]      x1_r;
  logic                    vld2_r;
  logic                    neg2_r;
  logic signed [32:0]      x2_r;
  logic [31:0]             abs2_r;
  logic [31:0]             abs_nxt;
  logic                    vld3_r;
  logic                    neg3_r;
  logic signed [32:0]      x3_r;
  logic [62:0]             mag3_r;
  logic [62:0]             mag_nxt;
  logic                    rnd_inc;
  logic [3:0]              q_nxt;
  logic                    vld4_r;
  logic                    neg4_r;
  logic signed [32:0]      x4_r;
  logic [3:0]              q4_r;
  logic [63:0]             npi;
  logic [63:0]             xs;
  logic [63:0]             r58_nxt;
  logic                    vld5_r;
  logic                    odd5_r;
  logic [63:0]             r58_5_r;
  logic [63:0]             r58_biased;
  logic                    vld6_r;
  logic                    odd6_r;
  q30_t                    r6_r;
  logic                    vld8;
  logic signed [32:0]      r2_8;
  logic signed [32:0]      r2_dly_r [0:3];
  q30_t                    r_dly_r [0:7];
  logic                    odd_dly_r [0:9];
  logic                    vld10;
  q30_t                    pb_10;
  logic                    vld12;
  q30_t                    pc_12;
  logic                    vld14;
  q30_t                    pd_14;
  logic                    vld16;
  logic signed [32:0]      y16;
  logic signed [32:0]      yn;
  q30_t                    ysat;
  logic                    out_strobe_r;
  logic signed [RESULT_WIDTH-1:0] out_value_r;

  // handshake
  assign busy = ~rst_n;
  assign acc  = start & ~busy;

  // clamp wide angles to the 32 bit range
  if (ANGLE_WIDTH > 32) begin : g_clamp
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MAX = ANGLE_WIDTH'(64'sh7FFF_FFFF);
    localparam logic signed [ANGLE_WIDTH-1:0] ANG_MIN = ANGLE_WIDTH'(-64'sh8000_0000);
    always_comb begin
      if (in_angle > ANG_MAX) begin
        ang_sat = 32'sh7FFF_FFFF;
      end else if (in_angle < ANG_MIN) begin
        ang_sat = 32'sh8000_0000;
      end else begin
        ang_sat = 32'(in_angle);
      end
    end
  end else begin : g_extend
    assign ang_sat = 32'(in_angle);
  end

  // stage 1: cosine shift by pi/2
  assign x1_nxt = 33'(ang_sat) + (in_command ? PI_HALF_Q27 : 33'sd0);

  // stage 2: magnitude and sign
  assign abs_nxt = x1_r[32] ? 32'(-x1_r) : 32'(x1_r);

  // stage 3: magnitude times 1/pi, exact in q59
  assign mag_nxt = 63'(abs2_r) * 63'(INV_PI_Q32);

  // stage 4: round the quotient to nearest, ties to even
  assign rnd_inc = mag3_r[58] & ((|mag3_r[57:0]) | mag3_r[59]);
  assign q_nxt   = mag3_r[62:59] + {3'd0, rnd_inc};

  // stage 5: r = x - n*pi in q58
  assign npi     = npi_of(q4_r);
  assign xs      = {x4_r, 31'd0};
  assign r58_nxt = neg4_r ? (xs + npi) : (xs - npi);

  // stage 6: q58 to q30, ties away from zero
  assign r58_biased = r58_5_r + 64'h0000_0000_0800_0000 - {63'd0, r58_5_r[63]};

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r       <= 1'b0;
      vld2_r       <= 1'b0;
      vld3_r       <= 1'b0;
      vld4_r       <= 1'b0;
      vld5_r       <= 1'b0;
      vld6_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      vld1_r       <= acc;
      vld2_r       <= vld1_r;
      vld3_r       <= vld2_r;
      vld4_r       <= vld3_r;
      vld5_r       <= vld4_r;
      vld6_r       <= vld5_r;
      out_strobe_r <= vld16;
    end
  end

  // range reduction data path
  always_ff @(posedge clk) begin
    x1_r    <= x1_nxt;
    neg2_r  <= x1_r[32];
    x2_r    <= x1_r;
    abs2_r  <= abs_nxt;
    neg3_r  <= neg2_r;
    x3_r    <= x2_r;
    mag3_r  <= mag_nxt;
    neg4_r  <= neg3_r;
    x4_r    <= x3_r;
    q4_r    <= q_nxt;
    odd5_r  <= q4_r[0];
    r58_5_r <= r58_nxt;
    odd6_r  <= odd5_r;
    r6_r    <= r58_biased[59:28];
  end

  // delay lines that keep r, r squared and the sign flip aligned
  always_ff @(posedge clk) begin
    r2_dly_r[0]  <= r2_8;
    r_dly_r[0]   <= r6_r;
    odd_dly_r[0] <= odd6_r;
    for (int i = 1; i < 4; i++) begin
      r2_dly_r[i] <= r2_dly_r[i-1];
    end
    for (int i = 1; i < 8; i++) begin
      r_dly_r[i] <= r_dly_r[i-1];
    end
    for (int i = 1; i < 10; i++) begin
      odd_dly_r[i] <= odd_dly_r[i-1];
    end
  end

  // r squared
  sincos_mac #(.AW(32), .BW(32), .CW(33)) u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld6_r),
    .in_a    (r6_r),
    .in_b    (r6_r),
    .in_c    (33'sd0),
    .out_vld (vld8),
    .out_res (r2_8)
  );

  // horner step: b + r2*a
  sincos_mac #(.AW(33), .BW(32), .CW(32)) u_hb (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld8),
    .in_a    (r2_8),
    .in_b    (COEF_A),
    .in_c    (COEF_B),
    .out_vld (vld10),
    .out_res (pb_10)
  );

  // horner step: c + r2*p
  sincos_mac #(.AW(33), .BW(32), .CW(32)) u_hc (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld10),
    .in_a    (r2_dly_r[1]),
    .in_b    (pb_10),
    .in_c    (COEF_C),
    .out_vld (vld12),
    .out_res (pc_12)
  );

  // horner step: d + r2*p
  sincos_mac #(.AW(33), .BW(32), .CW(32)) u_hd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld12),
    .in_a    (r2_dly_r[3]),
    .in_b    (pc_12),
    .in_c    (COEF_D),
    .out_vld (vld14),
    .out_res (pd_14)
  );

  // final product r*p
  sincos_mac #(.AW(32), .BW(32), .CW(33)) u_fy (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld14),
    .in_a    (r_dly_r[7]),
    .in_b    (pd_14),
    .in_c    (33'sd0),
    .out_vld (vld16),
    .out_res (y16)
  );

  // sign flip for odd half turns and clamp to plus or minus one
  assign yn = odd_dly_r[9] ? -y16 : y16;

  always_comb begin
    if (yn > 33'(ONE_Q30)) begin
      ysat = ONE_Q30;
    end else if (yn < -33'(ONE_Q30)) begin
      ysat = -ONE_Q30;
    end else begin
      ysat = 32'(yn);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    out_value_r <= RESULT_WIDTH'(ysat);
  end

  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;

endmodule

`default_nettype wire

// ----- rtl/core/sincos_chk.sv -----
// port level checker for the sine / cosine pipeline, bound to the top level
`default_nettype none

module sincos_chk #(
  parameter int ANGLE_WIDTH  = sincos_pkg::ANGLE_WIDTH_DEF,
  parameter int RESULT_WIDTH = sincos_pkg::RESULT_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_command,
  input logic signed [ANGLE_WIDTH-1:0]  in_angle,
  input logic                           out_strobe,
  input logic signed [RESULT_WIDTH-1:0] out_value
);
  import sincos_pkg::*;

  localparam int WW = $clog2(LATENCY + 1);

  logic          acc;
  logic          sin_zero;
  logic          warm;
  logic [WW-1:0] warm_r;

  assign acc      = start & ~busy;
  assign sin_zero = acc & ~in_command & (in_angle == '0);
  assign warm     = (warm_r == WW'(LATENCY));

  // edges since reset, saturating at the pipeline latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (!warm) begin
      warm_r <= warm_r + 1'b1;
    end
  end

  // every accepted word gives exactly one strobe, a fixed latency later
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_strobe == $past(acc, LATENCY)))
    else $error("strobe does not match accepted word");

  // sine of zero is exactly zero
  a_sine_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && $past(sin_zero, LATENCY)) |-> (out_value == '0))
    else $error("sine of zero is not zero");

  // result stays within plus or minus one
  if (RESULT_WIDTH >= 32) begin : g_range
    localparam logic signed [RESULT_WIDTH-1:0] VMAX = RESULT_WIDTH'(ONE_Q30);
    localparam logic signed [RESULT_WIDTH-1:0] VMIN = -VMAX;
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_strobe |-> ((out_value <= VMAX) && (out_value >= VMIN)))
      else $error("result outside plus or minus one");
  end

endmodule

bind sine_cosine_polynomial_approx sincos_chk #(
  .ANGLE_WIDTH  (ANGLE_WIDTH),
  .RESULT_WIDTH (RESULT_WIDTH)
) u_sincos_chk (.*);

`default_nettype wire
